### src/mcq_pkg.sv
package mcq_pkg;

    localparam int ID_FIELD_W  = 16;
    localparam int SEL_FIELD_W = 4;
    localparam int CAP_W       = 4;
    localparam int LEVEL_W     = 4;
    localparam int TOTAL_W     = 8;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        RC_ENQUEUED = 2'd0,
        RC_FULL     = 2'd1,
        RC_DEQUEUED = 2'd2,
        RC_EMPTY    = 2'd3
    } t_result_code;

    typedef struct packed {
        logic                   cmd;
        logic [SEL_FIELD_W-1:0] queue_sel;
        logic [ID_FIELD_W-1:0]  entry_id;
        logic                   entry_urgent;
    } t_in_item;

    typedef struct packed {
        t_result_code           result_code;
        logic [ID_FIELD_W-1:0]  out_id;
        logic                   out_urgent;
        logic [LEVEL_W-1:0]     queue_level;
        logic [TOTAL_W-1:0]     total_level;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic execute;
        logic load_out;
    } t_ctrl_cmd;

endpackage

### src/mcq_if.sv
interface mcq_in_if;
    logic              valid;
    logic              ready;
    mcq_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcq_out_if;
    logic               valid;
    logic               ready;
    mcq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/multi_class_bounded_fifo_queues.sv
// Per-class bounded FIFO queues.
// Commands arrive on i_in, a valid/ready channel carrying cmd, queue_sel, entry_id
// and entry_urgent; a transaction completes when valid and ready are both high.
// Each command yields exactly one result transaction on o_out with the result
// code, the popped entry (zero unless dequeued), the selected queue's level and
// the total level over all queues.
// The capacity register is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only whilst the block is idle, as the block does not enforce this.
// It resets to five; the capacity in effect saturates at the queue depth. A new
// command waits for the last one's execute step (read-modify-write of the queue
// counters and the entry store) and done step (the store's registered read).
// A stalled receiver holds the result in the output register; the block still
// takes and executes the next command, then waits until the register is free.
// Reset empties every queue and clears the total; stored entries are not cleared,
// since only written slots are ever read.
module multi_class_bounded_fifo_queues #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mcq_in_if.sink                    i_in,
    mcq_out_if.source                 o_out,
    input  logic                      i_cfg_wr_en,
    input  logic [mcq_pkg::CAP_W-1:0] i_cfg_wr_data
);
    import mcq_pkg::*;

    t_ctrl_cmd ctrl_cmd;

    mcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (ctrl_cmd)
    );

    mcq_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (i_in.data),
        .o_result      (o_out.data)
    );

endmodule

### src/mcq_ram.sv
module mcq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/mcq_ctrl.sv
module mcq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mcq_pkg::t_ctrl_cmd o_cmd
);
    import mcq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_ready;

    // The output register is free when empty or being emptied this cycle.
    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && out_free);

    assign o_cmd.load_in  = i_in_valid && in_ready;
    assign o_cmd.execute  = (r_state == S_EXEC);
    assign o_cmd.load_out = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = i_in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### src/mcq_datapath.sv
module mcq_datapath #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mcq_pkg::t_ctrl_cmd             i_cmd,
    input  logic                           i_cfg_wr_en,
    input  logic [mcq_pkg::CAP_W-1:0]      i_cfg_wr_data,
    input  mcq_pkg::t_in_item              i_req,
    output mcq_pkg::t_out_item             o_result
);
    import mcq_pkg::*;

    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW    = $clog2(SLOTS + 1);
    localparam int SW    = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;

    logic [CAP_W-1:0] r_capacity;
    logic [CW-1:0]    r_count [NUM_QUEUES];
    logic [PW-1:0]    r_head  [NUM_QUEUES];
    logic [TW-1:0]    r_total;
    t_in_item         r_req;
    t_result_code     r_code;
    logic [CW-1:0]    r_level;
    logic             r_deq_ok;
    t_out_item        r_out;

    logic             sel_ok;
    logic [QW-1:0]    q;
    logic [CW-1:0]    cnt;
    logic [PW-1:0]    head;
    logic             is_full;
    logic             enq_ok;
    logic             deq_ok;
    logic [31:0]      base;
    logic [31:0]      tail;
    logic [31:0]      slot;
    logic [PW-1:0]    n_head;
    logic [CW-1:0]    n_level;
    t_result_code     n_code;
    logic [AW-1:0]    mem_addr;
    logic [SW:0]      mem_wr_data;
    logic [SW:0]      mem_rd_data;

    always_comb begin
        sel_ok  = 32'(r_req.queue_sel) < NUM_QUEUES;
        q       = QW'(r_req.queue_sel);
        cnt     = '0;
        head    = '0;
        if (sel_ok) begin
            cnt  = r_count[q];
            head = r_head[q];
        end
        is_full = (32'(cnt) >= 32'(r_capacity)) || (32'(cnt) >= QUEUE_DEPTH);
        enq_ok  = sel_ok && (r_req.cmd == CMD_ENQUEUE) && !is_full;
        deq_ok  = sel_ok && (r_req.cmd == CMD_DEQUEUE) && (cnt != '0);

        // Head is below the depth and count at most the depth here, so one subtract wraps the tail.
        base = 32'(q) * QUEUE_DEPTH;
        tail = 32'(head) + 32'(cnt);
        if (tail >= QUEUE_DEPTH) begin
            tail = tail - QUEUE_DEPTH;
        end
        slot     = (r_req.cmd == CMD_ENQUEUE) ? (base + tail) : (base + 32'(head));
        mem_addr = AW'(slot);

        n_head = (32'(head) + 1 == QUEUE_DEPTH) ? '0 : head + PW'(1);

        if (enq_ok) begin
            n_level = cnt + CW'(1);
            n_code  = RC_ENQUEUED;
        end else if (deq_ok) begin
            n_level = cnt - CW'(1);
            n_code  = RC_DEQUEUED;
        end else begin
            n_level = cnt;
            n_code  = (r_req.cmd == CMD_ENQUEUE) ? RC_FULL : RC_EMPTY;
        end
    end

    assign mem_wr_data = {r_req.entry_id[SW-1:0], r_req.entry_urgent};

    mcq_ram #(
        .WIDTH (SW + 1),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.execute && enq_ok),
        .i_rd_en   (i_cmd.execute && deq_ok),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
            r_total    <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_cmd.execute) begin
                if (enq_ok) begin
                    r_count[q] <= n_level;
                    r_total    <= r_total + TW'(1);
                end else if (deq_ok) begin
                    r_count[q] <= n_level;
                    r_head[q]  <= n_head;
                    r_total    <= r_total - TW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req;
        end
        if (i_cmd.execute) begin
            r_code   <= n_code;
            r_level  <= n_level;
            r_deq_ok <= deq_ok;
        end
        // The store's read data arrives in the cycle after the execute step and holds.
        if (i_cmd.load_out) begin
            r_out.result_code <= r_code;
            r_out.out_id      <= r_deq_ok ? ID_FIELD_W'(mem_rd_data[SW:1]) : '0;
            r_out.out_urgent  <= r_deq_ok ? mem_rd_data[0] : 1'b0;
            r_out.queue_level <= LEVEL_W'(r_level);
            r_out.total_level <= TOTAL_W'(r_total);
        end
    end

    assign o_result = r_out;

endmodule

### src/mcq_checker.sv
module mcq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input mcq_pkg::t_out_item i_out_data
);
    import mcq_pkg::*;

    // A result waiting on the receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // Only a successful dequeue carries an entry.
    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.result_code != RC_DEQUEUED)
        |-> (i_out_data.out_id == '0) && !i_out_data.out_urgent)
        else $error("entry fields set on a result other than dequeued");

    // An empty report means the addressed queue holds nothing.
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.result_code == RC_EMPTY)
        |-> (i_out_data.queue_level == '0))
        else $error("empty reported with a non-zero queue level");

endmodule

bind multi_class_bounded_fifo_queues mcq_checker u_mcq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
